// ===== design/lcnc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcnc_pkg: shared types and constants of the card number check unit
// Widths of the binary/bcd datapath, sequencer states, control bundles
// and the small digit helpers used by the converter and the digit scan.
// ----------------------------------------------------------------------------
package lcnc_pkg;

	localparam int NUM_W         = 63;
	localparam int NUM_DIGITS    = 19;
	localparam int BCD_W         = NUM_DIGITS * 4;
	localparam int BITS_PER_STEP = 3;
	localparam int CONV_STEPS    = NUM_W / BITS_PER_STEP;
	localparam int PAIR_W        = 8;
	localparam int NUM_PAIRS     = (NUM_DIGITS + 1) / 2;
	localparam int STEP_W        = 5;
	localparam int PAIR_IDX_W    = 4;
	localparam int CNT_W         = 5;
	localparam int KIND_W        = 2;

	localparam logic [KIND_W-1:0] KIND_INVALID = 2'd0;
	localparam logic [KIND_W-1:0] KIND_AX      = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MC      = 2'd2;
	localparam logic [KIND_W-1:0] KIND_V       = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic shift_out;
	} bcd_ctl_t;

	typedef struct packed {
		logic clear;
		logic step;
	} scan_ctl_t;

	// shift-add-3 correction of one bcd digit
	function automatic logic [3:0] dabble_adj(input logic [3:0] d);
		return (d >= 4'd5) ? d + 4'd3 : d;
	endfunction

	// doubled digit with its two digits summed
	function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
		logic [3:0] r;
		case (d)
			4'd0:    r = 4'd0;
			4'd1:    r = 4'd2;
			4'd2:    r = 4'd4;
			4'd3:    r = 4'd6;
			4'd4:    r = 4'd8;
			4'd5:    r = 4'd1;
			4'd6:    r = 4'd3;
			4'd7:    r = 4'd5;
			4'd8:    r = 4'd7;
			4'd9:    r = 4'd9;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/lcnc_bcd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcnc_bcd: iterative binary to bcd converter
// Shift-add-3 over all digits, three input bits per pass. After conversion
// the bcd word is shifted down one digit pair at a time for the scan.
// ----------------------------------------------------------------------------
module lcnc_bcd import lcnc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bcd_ctl_t             ctl,
	input  logic [NUM_W-1:0]     num,
	output logic [3:0]           digit_lo,
	output logic [3:0]           digit_hi
);

	logic [NUM_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] rnd [0:BITS_PER_STEP];
	logic [BCD_W-1:0] adj;

	always_comb begin
		rnd[0] = bcd_q;
		adj    = '0;
		for (int r = 0; r < BITS_PER_STEP; r++) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				adj[i*4 +: 4] = dabble_adj(rnd[r][i*4 +: 4]);
			end
			rnd[r+1] = {adj[BCD_W-2:0], bin_q[NUM_W-1-r]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
			bcd_q <= '0;
		end else if (ctl.load) begin
			bin_q <= num;
			bcd_q <= '0;
		end else if (ctl.step) begin
			bin_q <= bin_q << BITS_PER_STEP;
			bcd_q <= rnd[BITS_PER_STEP];
		end else if (ctl.shift_out) begin
			bcd_q <= bcd_q >> PAIR_W;
		end
	end

	assign digit_lo = bcd_q[3:0];
	assign digit_hi = bcd_q[7:4];

endmodule

// ===== design/lcnc_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcnc_scan: luhn digit accumulator
// Takes two digits per step, least significant pair first. Keeps the luhn
// total modulo ten, the digit count and the two leading digits.
// ----------------------------------------------------------------------------
module lcnc_scan import lcnc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scan_ctl_t             ctl,
	input  logic [PAIR_IDX_W-1:0] pair_idx,
	input  logic [3:0]            digit_lo,
	input  logic [3:0]            digit_hi,
	output logic [CNT_W-1:0]      count,
	output logic [3:0]            lead,
	output logic [3:0]            second,
	output logic                  total_ok
);

	logic [3:0]       acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [3:0]       lead_q;
	logic [3:0]       second_q;
	logic [3:0]       prev_q;
	logic [4:0]       pair_sum;
	logic [4:0]       acc_sum;
	logic [3:0]       acc_next;

	// even position plain, odd position doubled
	assign pair_sum = {1'b0, digit_lo} + {1'b0, luhn_dbl(digit_hi)};
	assign acc_sum  = {1'b0, acc_q} + pair_sum;

	always_comb begin
		if (acc_sum >= 5'd20)
			acc_next = 4'(acc_sum - 5'd20);
		else if (acc_sum >= 5'd10)
			acc_next = 4'(acc_sum - 5'd10);
		else
			acc_next = acc_sum[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			cnt_q    <= '0;
			lead_q   <= '0;
			second_q <= '0;
			prev_q   <= '0;
		end else if (ctl.clear) begin
			acc_q    <= '0;
			cnt_q    <= '0;
			lead_q   <= '0;
			second_q <= '0;
			prev_q   <= '0;
		end else if (ctl.step) begin
			acc_q  <= acc_next;
			prev_q <= digit_hi;
			if (digit_hi != 4'd0) begin
				cnt_q    <= {pair_idx, 1'b0} + CNT_W'(2);
				lead_q   <= digit_hi;
				second_q <= digit_lo;
			end else if (digit_lo != 4'd0) begin
				// digit below the leading one sits in the previous pair
				cnt_q    <= {pair_idx, 1'b1};
				lead_q   <= digit_lo;
				second_q <= prev_q;
			end
		end
	end

	assign count    = cnt_q;
	assign lead     = lead_q;
	assign second   = second_q;
	assign total_ok = (acc_q == 4'd0);

endmodule

// ===== design/luhn_card_number_check_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_card_number_check_unit: luhn mod-10 card number check
// An item is taken when start is high and busy is low; busy then stays high
// through 21 passes of the shift-add-3 converter at three bits per pass,
// 10 steps of the digit scan at two digits per step and a classification
// state. The result appears on card_kind, checksum_ok and digit_count with
// done high for exactly one cycle, the first cycle with busy low, and must
// be taken then; done is not held. A new item may be started in that same
// cycle; the unit takes no new item while it is busy with the last one.
// ----------------------------------------------------------------------------
module luhn_card_number_check_unit import lcnc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [NUM_W-1:0]   card_number,
	output logic               done,
	output logic [KIND_W-1:0]  card_kind,
	output logic               checksum_ok,
	output logic [CNT_W-1:0]   digit_count
);

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic                done_q;
	logic [KIND_W-1:0]   kind_q;
	logic                ok_q;
	logic [CNT_W-1:0]    count_q;
	bcd_ctl_t            bcd_ctl;
	scan_ctl_t           scan_ctl;
	logic [3:0]          digit_lo;
	logic [3:0]          digit_hi;
	logic [CNT_W-1:0]    scan_count;
	logic [3:0]          scan_lead;
	logic [3:0]          scan_second;
	logic                scan_ok;
	logic [6:0]          lead_two;
	logic [KIND_W-1:0]   kind;
	logic                accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		bcd_ctl.load       = accept;
		bcd_ctl.step       = (state_q == ST_CONV);
		bcd_ctl.shift_out  = (state_q == ST_SCAN);
		scan_ctl.clear     = accept;
		scan_ctl.step      = (state_q == ST_SCAN);
	end

	lcnc_bcd u_bcd (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (bcd_ctl),
		.num      (card_number),
		.digit_lo (digit_lo),
		.digit_hi (digit_hi)
	);

	lcnc_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.pair_idx (step_q[PAIR_IDX_W-1:0]),
		.digit_lo (digit_lo),
		.digit_hi (digit_hi),
		.count    (scan_count),
		.lead     (scan_lead),
		.second   (scan_second),
		.total_ok (scan_ok)
	);

	// lead * 10 + second
	assign lead_two = {scan_lead, 3'b000} + {2'b00, scan_lead, 1'b0} + {3'b000, scan_second};

	always_comb begin
		kind = KIND_INVALID;
		if (scan_count == CNT_W'(15) && (lead_two inside {7'd34, 7'd37}))
			kind = KIND_AX;
		else if (scan_count == CNT_W'(16) && (lead_two inside {[7'd51:7'd55]}))
			kind = KIND_MC;
		else if ((scan_count inside {CNT_W'(13), CNT_W'(16)}) && scan_lead == 4'd4)
			kind = KIND_V;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CONV;
						step_q  <= '0;
					end
				end
				ST_CONV: begin
					if (step_q == STEP_W'(CONV_STEPS - 1)) begin
						state_q <= ST_SCAN;
						step_q  <= '0;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_SCAN: begin
					if (step_q == STEP_W'(NUM_PAIRS - 1)) begin
						state_q <= ST_DONE;
						step_q  <= '0;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					step_q  <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			kind_q  <= kind;
			ok_q    <= scan_ok;
			count_q <= scan_count;
		end
	end

	assign done        = done_q;
	assign card_kind   = kind_q;
	assign checksum_ok = ok_q;
	assign digit_count = count_q;

	a_done_after_classify: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_DONE))
		else $error("result strobe without classification cycle");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted item did not start conversion");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (digit_count <= CNT_W'(NUM_DIGITS)))
		else $error("digit count out of range");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && digit_count == '0) |-> (checksum_ok && card_kind == KIND_INVALID))
		else $error("zero input gave a bad result");

endmodule
